/* sv/rpdn_pkg.sv */
package rpdn_pkg;

  localparam int unsigned NUM_LANES   = 4;
  localparam int unsigned LEVEL_W     = 17;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned DUTY_W      = 14;
  // level * gain, unit 2^-30
  localparam int unsigned SCALED_W    = LEVEL_W + GAIN_W;
  // sum of four scaled intensities
  localparam int unsigned SUM_W       = SCALED_W + 2;
  localparam int unsigned FULL_SHIFT  = 30;
  localparam int unsigned PWM_TOP_DEF = 9999;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(16384);
  localparam logic [SUM_W-1:0]  FULL_UNIT  = SUM_W'(1) << FULL_SHIFT;

  localparam int unsigned IN_DATA_W  = ((NUM_LANES * LEVEL_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((NUM_LANES * DUTY_W + 7) / 8) * 8;

  // per-cycle control shared by the lanes and the merge stage
  typedef struct packed {
    logic ld_scale;  // capture level * gain
    logic ld_num;    // capture scaled * top, and the sum in the merge stage
    logic start;     // load the divider
    logic step;      // one quotient bit
  } lane_ctl_t;

endpackage

/* sv/rpdn_lane.sv */
module rpdn_lane #(
  parameter int unsigned PWM_TOP = rpdn_pkg::PWM_TOP_DEF,
  parameter int unsigned QUO_W   = $clog2(PWM_TOP + 1)
) (
  input  logic                             clk,
  input  rpdn_pkg::lane_ctl_t              ctl,
  input  logic [rpdn_pkg::LEVEL_W-1:0]     level,
  input  logic [rpdn_pkg::GAIN_W-1:0]      gain,
  input  logic [rpdn_pkg::SUM_W-1:0]       dvs,
  output logic [rpdn_pkg::SCALED_W-1:0]    scaled,
  output logic [QUO_W-1:0]                 quo
);
  import rpdn_pkg::*;

  localparam int unsigned NUM_W = SCALED_W + QUO_W;

  logic [SCALED_W-1:0] scaled_r;
  logic [SCALED_W-1:0] scaled_nxt;
  logic [NUM_W-1:0]    num_r;
  logic [NUM_W-1:0]    num_nxt;
  logic [SUM_W-1:0]    rem_r;
  logic [QUO_W-1:0]    quo_r;
  logic [SUM_W:0]      trial;
  logic [SUM_W:0]      diff;
  logic                q_bit;

  assign scaled_nxt = SCALED_W'(level) * SCALED_W'(gain);
  assign num_nxt    = NUM_W'(scaled_r) * NUM_W'(PWM_TOP);

  // restoring division, remainder always below the divisor
  assign trial = {rem_r, quo_r[QUO_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign q_bit = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (ctl.ld_scale) begin
      scaled_r <= scaled_nxt;
    end
    if (ctl.ld_num) begin
      num_r <= num_nxt;
    end
    if (ctl.start) begin
      // quotient fits in QUO_W bits, so the upper part is already below dvs
      rem_r <= SUM_W'(num_r[NUM_W-1:QUO_W]);
      quo_r <= num_r[QUO_W-1:0];
    end else if (ctl.step) begin
      rem_r <= q_bit ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      quo_r <= (quo_r << 1) | QUO_W'(q_bit);
    end
  end

  assign scaled = scaled_r;
  assign quo    = quo_r;

endmodule

/* sv/rpdn_merge.sv */
module rpdn_merge (
  input  logic                          clk,
  input  rpdn_pkg::lane_ctl_t           ctl,
  input  logic [rpdn_pkg::SCALED_W-1:0] scaled [rpdn_pkg::NUM_LANES],
  output logic [rpdn_pkg::SUM_W-1:0]    dvs,
  output logic                          limited
);
  import rpdn_pkg::*;

  logic [SUM_W-1:0] sum;
  logic             over;
  logic [SUM_W-1:0] div_r;
  logic             lim_r;
  logic [SUM_W-1:0] dvs_r;
  logic             lim_run_r;

  always_comb begin
    sum = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sum = sum + SUM_W'(scaled[i]);
    end
  end

  // exactly one full unit is not limited
  assign over = (sum > FULL_UNIT);

  always_ff @(posedge clk) begin
    if (ctl.ld_num) begin
      div_r <= over ? sum : FULL_UNIT;
      lim_r <= over;
    end
    if (ctl.start) begin
      dvs_r     <= div_r;
      lim_run_r <= lim_r;
    end
  end

  assign dvs     = dvs_r;
  assign limited = lim_run_r;

endmodule

/* sv/rgbw_pwm_duty_normalizer.sv */
// rgbw pwm duty normaliser
//
// in channel: one word carries red, green, blue and white levels (unsigned,
// 65536 = full). each level is scaled by the brightness gain (q2.14); if the
// four scaled levels add up to more than one full unit they are all divided
// by their sum. every channel then becomes floor(intensity * PWM_TOP).
// out channel: one word of four duty values plus the limited flag in tuser.
// cfg port: cfg_we writes brightness_gain; only while the block is idle.
//
// each lane divider yields QUO_W = clog2(PWM_TOP + 1) quotient bits, one per
// step; the four bit-serial restoring dividers, one per lane, run side by side
// and a division must finish before the next word can enter them.
// the scale and multiply stages ahead of the dividers take the next words
// while a division runs, and the output register holds a finished result
// while the dividers work on the next one.
// reset: gain returns to 1.0, all pipeline stages and the output empty.
// receiver stall: the result waits in the output register; the dividers
// hold their finished quotients, then the front stages fill and in_tready
// drops until out_tready returns.
module rgbw_pwm_duty_normalizer #(
  parameter int unsigned PWM_TOP = rpdn_pkg::PWM_TOP_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // cfg: brightness_gain
  input  logic                              cfg_we,
  input  logic [rpdn_pkg::GAIN_W-1:0]       cfg_wdata,
  // in_tdata: red_level, green_level, blue_level, white_level, zero pad
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rpdn_pkg::IN_DATA_W-1:0]    in_tdata,
  // out_tdata: red_duty, green_duty, blue_duty, white_duty
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rpdn_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: was_limited
  output logic [0:0]                        out_tuser
);
  import rpdn_pkg::*;

  localparam int unsigned QUO_W = $clog2(PWM_TOP + 1);
  localparam int unsigned CNT_W = (QUO_W > 1) ? $clog2(QUO_W) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

  logic [GAIN_W-1:0]   gain_r;
  lane_ctl_t           ctl;
  logic [SCALED_W-1:0] scaled [NUM_LANES];
  logic [QUO_W-1:0]    quo    [NUM_LANES];
  logic [SUM_W-1:0]    dvs;
  logic                limited;

  // pipeline occupancy
  logic             scale_vld_r;  // scaled levels held in the lanes
  logic             num_vld_r;    // products and divisor held
  logic             run_r;        // dividers stepping
  logic             fin_r;        // quotients ready, waiting for output
  logic [CNT_W-1:0] cnt_r;
  logic             out_vld_r;
  logic [DUTY_W-1:0] duty_r [NUM_LANES];
  logic             lim_out_r;

  logic in_acc;
  logic out_ld;
  logic div_free;
  logic last_step;

  // gain register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_we) begin
      gain_r <= cfg_wdata;
    end
  end

  // control: each stage moves when the one after it is free or emptying
  assign out_ld      = fin_r && (!out_vld_r || out_tready);
  assign div_free    = !run_r && (!fin_r || out_ld);
  assign ctl.start   = num_vld_r && div_free;
  assign ctl.ld_num  = scale_vld_r && (!num_vld_r || ctl.start);
  assign in_tready   = !scale_vld_r || ctl.ld_num;
  assign in_acc      = in_tvalid && in_tready;
  assign ctl.ld_scale = in_acc;
  assign ctl.step    = run_r;
  assign last_step   = run_r && (cnt_r == CNT_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_vld_r <= 1'b0;
      num_vld_r   <= 1'b0;
      run_r       <= 1'b0;
      fin_r       <= 1'b0;
      cnt_r       <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        scale_vld_r <= 1'b1;
      end else if (ctl.ld_num) begin
        scale_vld_r <= 1'b0;
      end

      if (ctl.ld_num) begin
        num_vld_r <= 1'b1;
      end else if (ctl.start) begin
        num_vld_r <= 1'b0;
      end

      if (ctl.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (last_step) begin
        run_r <= 1'b0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
      end

      if (last_step) begin
        fin_r <= 1'b1;
      end else if (out_ld) begin
        fin_r <= 1'b0;
      end

      if (out_ld) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // lanes: scale, multiply by top, divide
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    rpdn_lane #(
      .PWM_TOP (PWM_TOP),
      .QUO_W   (QUO_W)
    ) u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .level  (in_tdata[i*LEVEL_W +: LEVEL_W]),
      .gain   (gain_r),
      .dvs    (dvs),
      .scaled (scaled[i]),
      .quo    (quo[i])
    );
  end

  // merge: sum of the lanes picks the common divisor
  rpdn_merge u_merge (
    .clk     (clk),
    .ctl     (ctl),
    .scaled  (scaled),
    .dvs     (dvs),
    .limited (limited)
  );

  // output register, quotient never exceeds top so only the width is fitted
  always_ff @(posedge clk) begin
    if (out_ld) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        duty_r[i] <= DUTY_W'(quo[i]);
      end
      lim_out_r <= limited;
    end
  end

  always_comb begin
    out_tdata = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      out_tdata[i*DUTY_W +: DUTY_W] = duty_r[i];
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tuser[0] = lim_out_r;

  // checks
  a_run_fin_excl : assert property (@(posedge clk) disable iff (!rst_n)
    !(run_r && fin_r))
    else $error("divider running and finished at once");

  a_start_idle : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !run_r)
    else $error("divider restarted while stepping");

  a_fin_after_run : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fin_r) |-> $past(run_r))
    else $error("quotients flagged ready without a division");

  a_quo_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> (quo[0] <= QUO_W'(PWM_TOP)) && (quo[1] <= QUO_W'(PWM_TOP)) &&
              (quo[2] <= QUO_W'(PWM_TOP)) && (quo[3] <= QUO_W'(PWM_TOP)))
    else $error("duty quotient above pwm top");

  a_out_from_fin : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(fin_r))
    else $error("output word loaded without finished quotients");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import rpdn_pkg::*;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [GAIN_W-1:0]  gain_t;
  typedef logic [DUTY_W-1:0]  duty_t;

  // one input word, red in the lowest bits as on in_tdata
  typedef struct packed {
    level_t white;
    level_t blue;
    level_t green;
    level_t red;
  } colour_word_t;

  // one result word plus the limited flag
  typedef struct packed {
    logic  limited;
    duty_t white;
    duty_t blue;
    duty_t green;
    duty_t red;
  } duty_set_t;

  // directed stimulus row: gain in force, levels, and a hand-worked answer if known
  typedef struct packed {
    gain_t  gain;
    level_t r, g, b, w;
    logic   known;
    duty_t  dr, dg, db, dw;
    logic   lim;
  } dir_row_t;

  localparam int N_DIR = 23;
  localparam int WORDS_PER_CHUNK = 100;
  localparam int CHUNKS_PER_PHASE = 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  gain_t cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0] out_tuser;

  gain_t gain_now = GAIN_RESET;   // the gain the block should be using
  duty_set_t pending_duties [$];  // results still owed by the block, oldest first
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  dir_row_t directed_rows [N_DIR] = '{
    // unity gain: single full channels, exact full unit, over-range levels
    '{16384,      0,      0,      0,      0, 1,    0,    0,    0,    0, 0},
    '{16384,  65536,      0,      0,      0, 1, 9999,    0,    0,    0, 0},
    '{16384,      0,  65536,      0,      0, 1,    0, 9999,    0,    0, 0},
    '{16384,      0,      0,  65536,      0, 1,    0,    0, 9999,    0, 0},
    '{16384,      0,      0,      0,  65536, 1,    0,    0,    0, 9999, 0},
    '{16384,  16384,  16384,  16384,  16384, 1, 2499, 2499, 2499, 2499, 0},
    '{16384,  65536,  65536,  65536,  65536, 1, 2499, 2499, 2499, 2499, 1},
    '{16384, 131071, 131071, 131071, 131071, 1, 2499, 2499, 2499, 2499, 1},
    '{16384, 131071,      0,      0,      0, 1, 9999,    0,    0,    0, 1},
    '{16384,      0,      0,      0, 131071, 1,    0,    0,    0, 9999, 1},
    '{16384,      1,      0,      0,      0, 1,    0,    0,    0,    0, 0},
    '{16384,  32768,  16384,   8192,   4096, 0,    0,    0,    0,    0, 0},
    '{16384,  65536,      1,      0,      0, 0,    0,    0,    0,    0, 0},
    '{16384,  87381,  43690,  87381,  43690, 0,    0,    0,    0,    0, 0},
    '{16384,  40000,  30000,  20000,  10000, 0,    0,    0,    0,    0, 0},
    // zero gain wipes everything
    '{    0, 131071, 131071, 131071, 131071, 1,    0,    0,    0,    0, 0},
    '{    0,  65536,      0,      0,      0, 1,    0,    0,    0,    0, 0},
    // largest gain
    '{65535,  65536,      0,      0,      0, 1, 9999,    0,    0,    0, 1},
    '{65535,      0,      0,      0,      0, 1,    0,    0,    0,    0, 0},
    '{65535,      1,      1,      1,      1, 0,    0,    0,    0,    0, 0},
    '{65535,   4096,   4096,   4096,   4096, 0,    0,    0,    0,    0, 0},
    // smallest nonzero gain
    '{    1, 131071, 131071, 131071, 131071, 0,    0,    0,    0,    0, 0},
    '{    1,  65536,      0,      0,      0, 1,    0,    0,    0,    0, 0}
  };

  rgbw_pwm_duty_normalizer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // scale by gain, normalise by the sum when it passes one unit, map onto the timer top
  function automatic duty_set_t predict_duties(colour_word_t c, gain_t g);
    logic [63:0] scaled [NUM_LANES];
    logic [63:0] total;
    logic [63:0] divisor;
    logic [63:0] q;
    duty_t d [NUM_LANES];
    duty_set_t res;
    scaled[0] = 64'(c.red) * 64'(g);
    scaled[1] = 64'(c.green) * 64'(g);
    scaled[2] = 64'(c.blue) * 64'(g);
    scaled[3] = 64'(c.white) * 64'(g);
    total = scaled[0] + scaled[1] + scaled[2] + scaled[3];
    res.limited = (total > (64'd1 << FULL_SHIFT));
    divisor = res.limited ? total : (64'd1 << FULL_SHIFT);
    for (int i = 0; i < NUM_LANES; i++) begin
      q = (scaled[i] * 64'(PWM_TOP_DEF)) / divisor;
      if (q > 64'(PWM_TOP_DEF))
        q = 64'(PWM_TOP_DEF);
      d[i] = q[DUTY_W-1:0];
    end
    res.red = d[0];
    res.green = d[1];
    res.blue = d[2];
    res.white = d[3];
    return res;
  endfunction

  function automatic level_t pick_level(int mode);
    level_t lv;
    case (mode)
      0, 1: lv = level_t'($urandom_range(0, 16384));
      2, 3, 4: lv = level_t'($urandom_range(0, 65536));
      5: lv = level_t'($urandom_range(0, 131071));
      7: begin
        case ($urandom_range(0, 4))
          0: lv = 0;
          1: lv = 1;
          2: lv = 65535;
          3: lv = 65536;
          default: lv = 131071;
        endcase
      end
      default: lv = level_t'($urandom_range(0, 24000));
    endcase
    return lv;
  endfunction

  // mostly realistic colours, some near the full-unit boundary, some over-range
  function automatic colour_word_t random_colour();
    colour_word_t c;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 6) begin
      c = '0;
      case ($urandom_range(0, 3))
        0: c.red = level_t'($urandom_range(0, 131071));
        1: c.green = level_t'($urandom_range(0, 131071));
        2: c.blue = level_t'($urandom_range(0, 131071));
        default: c.white = level_t'($urandom_range(0, 131071));
      endcase
    end else begin
      c.red = pick_level(mode);
      c.green = pick_level(mode);
      c.blue = pick_level(mode);
      c.white = pick_level(mode);
    end
    return c;
  endfunction

  function automatic gain_t random_gain();
    case ($urandom_range(0, 7))
      0: return gain_t'(0);
      1: return gain_t'(65535);
      2: return GAIN_RESET;
      3: return gain_t'($urandom_range(0, 4096));
      4: return gain_t'($urandom_range(8192, 24576));
      default: return gain_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // offer one word, with random sender gaps; the answer is recorded when it is taken
  task automatic send_word(colour_word_t c, logic known, duty_set_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_DATA_W - NUM_LANES * LEVEL_W){1'b0}}, c};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    pending_duties.push_back(known ? want : predict_duties(c, gain_now));
  endtask

  // stop sending and let every owed result come out
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_duties.size() != 0)
      @(posedge clk);
  endtask

  // gain register is only touched once the pipe is empty
  task automatic write_gain(gain_t g);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(negedge clk);
    cfg_we <= 1'b0;
    gain_now = g;
  endtask

  // receiver back-pressure
  always @(negedge clk)
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  // result checker: each word taken is matched against the oldest owed result
  always @(posedge clk) begin
    duty_set_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_duties.size() == 0) begin
        $error("result word with nothing owed: tdata %h tuser %b", out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        want = pending_duties.pop_front();
        if (out_tdata[0 +: DUTY_W] !== want.red) begin
          $error("red_duty: expected %0d, got %0d", want.red, out_tdata[0 +: DUTY_W]);
          mismatch_count++;
        end
        if (out_tdata[DUTY_W +: DUTY_W] !== want.green) begin
          $error("green_duty: expected %0d, got %0d", want.green,
                 out_tdata[DUTY_W +: DUTY_W]);
          mismatch_count++;
        end
        if (out_tdata[2*DUTY_W +: DUTY_W] !== want.blue) begin
          $error("blue_duty: expected %0d, got %0d", want.blue,
                 out_tdata[2*DUTY_W +: DUTY_W]);
          mismatch_count++;
        end
        if (out_tdata[3*DUTY_W +: DUTY_W] !== want.white) begin
          $error("white_duty: expected %0d, got %0d", want.white,
                 out_tdata[3*DUTY_W +: DUTY_W]);
          mismatch_count++;
        end
        if (out_tuser[0] !== want.limited) begin
          $error("was_limited: expected %0d, got %0d", want.limited, out_tuser[0]);
          mismatch_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    duty_set_t want;
    colour_word_t c;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed rows, no gaps on either side
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].gain !== gain_now)
        write_gain(directed_rows[i].gain);
      c.red = directed_rows[i].r;
      c.green = directed_rows[i].g;
      c.blue = directed_rows[i].b;
      c.white = directed_rows[i].w;
      want.red = directed_rows[i].dr;
      want.green = directed_rows[i].dg;
      want.blue = directed_rows[i].db;
      want.white = directed_rows[i].dw;
      want.limited = directed_rows[i].lim;
      send_word(c, directed_rows[i].known, want);
    end

    // random part: four idling phases, fresh gain every chunk
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      for (int chunk = 0; chunk < CHUNKS_PER_PHASE; chunk++) begin
        write_gain(random_gain());
        for (int n = 0; n < WORDS_PER_CHUNK; n++) begin
          // a mid-chunk pause that lets the pipe empty with the gain unchanged
          if (n == WORDS_PER_CHUNK / 2 && chunk == 1)
            drain();
          send_word(random_colour(), 1'b0, '0);
        end
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (pending_duties.size() != 0) begin
      $error("%0d result words never arrived", pending_duties.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* filelist.f */
sv/rpdn_pkg.sv
sv/rpdn_lane.sv
sv/rpdn_merge.sv
sv/rgbw_pwm_duty_normalizer.sv
tb/sv/tb.sv
